// ===== design/wildcard_byte_pattern_scanner_assert.svh =====
// Assertion macros for the wildcard byte pattern scanner.
// Used by the top level only; it needs no package.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define WBPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define WBPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/wbps_pkg.sv =====
// Package for the wildcard byte pattern scanner: sizes, register indexes,
// payload structs. Depends on nothing.
`default_nettype none

package wbps_pkg;

	localparam int MAX_PATTERN_BYTES = 16;
	localparam int LEN_W             = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int PLEN_W            = 5;
	localparam int CFG_W             = 64;
	localparam int CFG_IDX_W         = 3;
	localparam int ADDR_W            = 32;
	localparam int OCC_W             = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW  = 3'd0,
		REG_PATTERN_HIGH = 3'd1,
		REG_CARE_LOW     = 3'd2,
		REG_CARE_HIGH    = 3'd3,
		REG_LENGTH       = 3'd4,
		REG_OCCURRENCE   = 3'd5,
		REG_BASE         = 3'd6,
		REG_OFFSET       = 3'd7
	} cfg_reg_t;

	localparam logic STATUS_FOUND     = 1'b0;
	localparam logic STATUS_NOT_FOUND = 1'b1;

	typedef logic [MAX_PATTERN_BYTES-1:0][7:0] lane_vec_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic              scan_status;
		logic [ADDR_W-1:0] match_address;
	} out_item_t;

endpackage

`default_nettype wire

// ===== design/wbps_window_match.sv =====
// Masked compare of the byte window against the pattern, for every length.
// Depends on wbps_pkg.
`default_nettype none

module wbps_window_match
	import wbps_pkg::*;
(
	input  wire lane_vec_t        win,
	input  wire lane_vec_t        pat,
	input  wire lane_vec_t        care,
	input  wire logic [LEN_W-1:0] len,
	input  wire logic [LEN_W-1:0] fill,
	output logic                  hit
);

	logic [MAX_PATTERN_BYTES:0] hit_by_len;

	// window slot 0 is the newest byte, so pattern byte i pairs with slot len-1-i
	always_comb begin
		hit_by_len = '0;
		for (int l = 1; l <= MAX_PATTERN_BYTES; l++) begin
			hit_by_len[l] = 1'b1;
			for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
				if (i < l) begin
					if (((win[l-1-i] ^ pat[i]) & care[i]) != 8'h00)
						hit_by_len[l] = 1'b0;
				end
			end
		end
	end

	assign hit = (len != '0) && (fill >= len) && hit_by_len[len];

endmodule

`default_nettype wire

// ===== design/wildcard_byte_pattern_scanner.sv =====
// Top level of the wildcard byte pattern scanner: input register, scan state,
// result register. Depends on wbps_pkg, wbps_window_match and the assert header.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+---------------------------------
//   input    | in_valid / in_ready     | in_item  (data_byte, last_byte)
//   result   | out_valid / out_ready   | out_item (scan_status, match_address)
//   config   | cfg_we                  | cfg_index, cfg_data
//
// One byte per cycle if no result stalls; results pass the input, then the result register.
// The window compare for every length is combinational between the input and
// result registers. A byte that gives a result waits in the input register
// while the result register is full; bytes without a result never wait.
// Reset clears the scan state at once; there is no clearing pass.
`default_nettype none

`include "wildcard_byte_pattern_scanner_assert.svh"

module wildcard_byte_pattern_scanner
	import wbps_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_item_t             in_item,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output out_item_t                 out_item,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	// configuration
	logic [2*CFG_W-1:0]  pattern_q;
	logic [2*CFG_W-1:0]  care_q;
	logic [PLEN_W-1:0]   pattern_length_q;
	logic [OCC_W-1:0]    occurrence_q;
	logic [ADDR_W-1:0]   base_q;
	logic [ADDR_W-1:0]   offset_q;

	// input stage
	logic     valid_s1;
	in_item_t item_s1;

	// scan state
	lane_vec_t         win_q;
	logic [ADDR_W-1:0] bytes_seen_q;
	logic [OCC_W-1:0]  matches_q;
	logic              reported_q;
	logic [LEN_W-1:0]  fill_q;

	// result register
	logic      out_valid_q;
	out_item_t out_item_q;

	// next-state logic
	lane_vec_t         win_next;
	logic [LEN_W-1:0]  fill_next;
	logic [ADDR_W-1:0] bytes_next;
	logic [PLEN_W-1:0] len_clamp;
	logic [LEN_W-1:0]  len_used;
	logic              hit;
	logic              found;
	logic              res_gen;
	logic              advance;
	out_item_t         res;
	logic [ADDR_W-1:0] start_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q        <= '0;
			care_q           <= '0;
			pattern_length_q <= PLEN_W'(1);
			occurrence_q     <= '0;
			base_q           <= '0;
			offset_q         <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PATTERN_LOW:  pattern_q[CFG_W-1:0]       <= cfg_data;
				REG_PATTERN_HIGH: pattern_q[2*CFG_W-1:CFG_W] <= cfg_data;
				REG_CARE_LOW:     care_q[CFG_W-1:0]          <= cfg_data;
				REG_CARE_HIGH:    care_q[2*CFG_W-1:CFG_W]    <= cfg_data;
				REG_LENGTH:       pattern_length_q           <= cfg_data[PLEN_W-1:0];
				REG_OCCURRENCE:   occurrence_q               <= cfg_data[OCC_W-1:0];
				REG_BASE:         base_q                     <= cfg_data[ADDR_W-1:0];
				REG_OFFSET:       offset_q                   <= cfg_data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	assign len_clamp = (pattern_length_q > PLEN_W'(MAX_PATTERN_BYTES)) ?
		PLEN_W'(MAX_PATTERN_BYTES) : pattern_length_q;
	assign len_used  = len_clamp[LEN_W-1:0];

	always_comb begin
		win_next    = win_q;
		win_next[0] = item_s1.data_byte;
		for (int k = 1; k < MAX_PATTERN_BYTES; k++)
			win_next[k] = win_q[k-1];
	end

	assign fill_next  = (fill_q == LEN_W'(MAX_PATTERN_BYTES)) ? fill_q : fill_q + 1'b1;
	assign bytes_next = bytes_seen_q + 1'b1;

	wbps_window_match u_match (
		.win  (win_next),
		.pat  (lane_vec_t'(pattern_q[MAX_PATTERN_BYTES*8-1:0])),
		.care (lane_vec_t'(care_q[MAX_PATTERN_BYTES*8-1:0])),
		.len  (len_used),
		.fill (fill_next),
		.hit  (hit)
	);

	assign found     = !reported_q && hit && (matches_q == occurrence_q);
	assign start_idx = bytes_next - ADDR_W'(len_used);
	assign res_gen   = found || (!reported_q && item_s1.last_byte);

	always_comb begin
		if (found) begin
			res.scan_status   = STATUS_FOUND;
			res.match_address = base_q + start_idx + offset_q;
		end else begin
			res.scan_status   = STATUS_NOT_FOUND;
			res.match_address = '0;
		end
	end

	// an item with no result never waits for the result register
	assign advance  = valid_s1 && (!res_gen || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q        <= '0;
			bytes_seen_q <= '0;
			matches_q    <= '0;
			reported_q   <= 1'b0;
			fill_q       <= '0;
		end else if (advance) begin
			if (item_s1.last_byte) begin
				win_q        <= '0;
				bytes_seen_q <= '0;
				matches_q    <= '0;
				reported_q   <= 1'b0;
				fill_q       <= '0;
			end else if (!reported_q) begin
				win_q        <= win_next;
				bytes_seen_q <= bytes_next;
				fill_q       <= fill_next;
				if (found)
					reported_q <= 1'b1;
				else if (hit)
					matches_q <= matches_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_gen) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_gen)
			out_item_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`WBPS_ASSERT_NXT(a_held_item_kept, clk, arst_n,
		valid_s1 && res_gen && out_valid_q && !out_ready, valid_s1,
		"item with a pending result dropped while result register full")
	`WBPS_ASSERT_IMP(a_not_found_zero, clk, arst_n,
		out_valid_q && (out_item_q.scan_status == STATUS_NOT_FOUND),
		out_item_q.match_address == '0, "not-found result carries an address")
	`WBPS_ASSERT_IMP(a_fill_bounded, clk, arst_n,
		1'b1, fill_q <= LEN_W'(MAX_PATTERN_BYTES), "window fill count overran")

endmodule

`default_nettype wire
